### rtl/trte_pkg.sv
package trte_pkg;

   // Result queue sizing: one beat may push two results, so the input side
   // is held off unless two slots are free.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_TAG0   = 3'd0,
      PH_TAG1   = 3'd1,
      PH_TAG2   = 3'd2,
      PH_LEN_LO = 3'd3,
      PH_LEN_HI = 3'd4,
      PH_VALUE  = 3'd5,
      PH_CHECK  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_OVERRUN   = 2'd2
   } status_type;

   typedef enum logic {
      KIND_VALUE  = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CSR_TAG_FIRST_CHAR  = 2'd0,
      CSR_TAG_NAME_LENGTH = 2'd1,
      CSR_TAG_NAME_XOR    = 2'd2,
      CSR_VALUE_LIMIT     = 2'd3
   } csr_index_type;

   localparam logic [15:0] VALUE_LIMIT_RESET = 16'd32;

   typedef struct packed {
      logic [7:0]  tag_first_char;
      logic [7:0]  tag_name_length;
      logic [7:0]  tag_name_xor;
      logic [15:0] value_limit;
   } cfg_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  value_byte;
      logic [1:0]  status_code;
      logic [15:0] value_count;
   } result_type;

   // Results produced by one accepted beat, res0 first.
   typedef struct packed {
      logic [1:0] num;
      result_type res0;
      result_type res1;
   } push_type;

endpackage

### rtl/trte_parser.sv
module trte_parser
   import trte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] msg_byte,
   input  logic       msg_last,
   input  cfg_type    cfg,
   output push_type   push
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  match_ff, match_in;
   logic [7:0]  len_lo_ff, len_lo_in;
   logic [15:0] remain_ff, remain_in;
   logic        in_match_ff, in_match_in;
   logic        found_ff, found_in;
   logic [15:0] delivered_ff, delivered_in;

   logic        on_boundary;
   logic        emit_value;
   logic [15:0] remain_dec;
   logic [15:0] len_word;
   result_type  value_res;
   result_type  status_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TAG0;
         match_ff     <= '0;
         len_lo_ff    <= '0;
         remain_ff    <= '0;
         in_match_ff  <= 1'b0;
         found_ff     <= 1'b0;
         delivered_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         match_ff     <= match_in;
         len_lo_ff    <= len_lo_in;
         remain_ff    <= remain_in;
         in_match_ff  <= in_match_in;
         found_ff     <= found_in;
         delivered_ff <= delivered_in;
      end
   end

   assign remain_dec = remain_ff - 16'd1;
   assign len_word   = {msg_byte, len_lo_ff};

   always_comb begin
      phase_in     = phase_ff;
      match_in     = match_ff;
      len_lo_in    = len_lo_ff;
      remain_in    = remain_ff;
      in_match_in  = in_match_ff;
      found_in     = found_ff;
      delivered_in = delivered_ff;
      on_boundary  = 1'b0;
      emit_value   = 1'b0;

      case (phase_ff)
         PH_TAG0: begin
            if (msg_byte == cfg.tag_first_char) match_in[0] = 1'b1;
            phase_in = PH_TAG1;
         end
         PH_TAG1: begin
            if (msg_byte == cfg.tag_name_length) match_in[1] = 1'b1;
            phase_in = PH_TAG2;
         end
         PH_TAG2: begin
            if (msg_byte == cfg.tag_name_xor) match_in[2] = 1'b1;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_lo_in = msg_byte;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            remain_in = len_word;
            // only the first matching record is delivered
            if (match_ff == 3'b111 && !found_ff) begin
               found_in    = 1'b1;
               in_match_in = 1'b1;
            end
            match_in = '0;
            if (len_word == 16'd0) begin
               in_match_in = 1'b0;
               phase_in    = PH_CHECK;
            end else begin
               phase_in = PH_VALUE;
            end
         end
         PH_VALUE: begin
            if (in_match_ff && delivered_ff < cfg.value_limit) begin
               emit_value   = 1'b1;
               delivered_in = delivered_ff + 16'd1;
            end
            remain_in = remain_dec;
            if (remain_dec == 16'd0) begin
               in_match_in = 1'b0;
               phase_in    = PH_CHECK;
            end
         end
         default: begin
            // check byte (or a phase that cannot occur): record ends here
            phase_in    = PH_TAG0;
            match_in    = '0;
            on_boundary = 1'b1;
         end
      endcase

      if (msg_last) begin
         phase_in     = PH_TAG0;
         match_in     = '0;
         len_lo_in    = '0;
         remain_in    = '0;
         in_match_in  = 1'b0;
         found_in     = 1'b0;
         delivered_in = '0;
      end
   end

   always_comb begin
      value_res.out_kind     = KIND_VALUE;
      value_res.value_byte   = msg_byte;
      value_res.status_code  = ST_FOUND;
      value_res.value_count  = '0;

      status_res.out_kind    = KIND_STATUS;
      status_res.value_byte  = '0;
      if (!on_boundary)  status_res.status_code = ST_OVERRUN;
      else if (found_ff) status_res.status_code = ST_FOUND;
      else               status_res.status_code = ST_NOT_FOUND;
      // count includes a value byte delivered by this same beat
      status_res.value_count = emit_value ? delivered_ff + 16'd1 : delivered_ff;

      push.res1 = status_res;
      if (emit_value) begin
         push.res0 = value_res;
         push.num  = msg_last ? 2'd2 : 2'd1;
      end else begin
         push.res0 = status_res;
         push.num  = msg_last ? 2'd1 : 2'd0;
      end
      if (!accept) push.num = 2'd0;
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && msg_last |=> phase_ff == PH_TAG0 && delivered_ff == 16'd0 && !found_ff)
      else $error("message state not cleared after final beat");

   a_limit: assert property (@(posedge clock) disable iff (reset)
      accept && emit_value |-> delivered_ff < cfg.value_limit)
      else $error("value byte delivered past limit");

   a_match_found: assert property (@(posedge clock) disable iff (reset)
      in_match_ff |-> found_ff && phase_ff == PH_VALUE)
      else $error("inside matching record without found flag");

   a_two_only_last: assert property (@(posedge clock) disable iff (reset)
      push.num == 2'd2 |-> msg_last && push.res1.out_kind == KIND_STATUS)
      else $error("two results from a non-final beat");

endmodule

### rtl/trte_rsp_fifo.sv
module trte_rsp_fifo
   import trte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       pop,
   output result_type head,
   output logic       not_empty,
   output logic       room_two
);

   result_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic [FIFO_PTR_W-1:0] wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + 1'b1;
   assign wr_ptr_in   = wr_ptr_ff + FIFO_PTR_W'(push.num);
   assign rd_ptr_in   = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign cnt_in      = cnt_ff + FIFO_CNT_W'(push.num) - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) mem_ff[wr_ptr_ff]   <= push.res0;
      if (push.num == 2'd2) mem_ff[wr_ptr_next] <= push.res1;
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = cnt_ff != '0;
   assign room_two  = cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.num != 2'd0 |-> 32'(cnt_ff) + 32'(push.num) <= FIFO_DEPTH)
      else $error("result queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("result queue underflow");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      FIFO_PTR_W'(wr_ptr_ff - rd_ptr_ff) == FIFO_PTR_W'(cnt_ff))
      else $error("queue pointers disagree with fill count");

endmodule

### rtl/tlv_record_tag_extractor.sv
// Channel | Direction | Handshake             | Beat payload
// req     | in        | req_valid / req_ready | req_msg_byte, req_msg_last
// rsp     | out       | rsp_valid / rsp_ready | rsp_out_kind, rsp_value_byte,
//         |           |                       | rsp_status_code, rsp_value_count
// csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// One message byte per cycle while req_ready is high. A byte's results land
// in the result queue when accepted and appear on rsp next cycle at the earliest.
// The final byte can push two results (value, then status); req_ready drops
// while fewer than two of the four queue slots are free.
// Reset (synchronous) clears parse state, the queue and the registers
// (tag registers to 0, value limit to 32). csr_ready is always high.
// A stalled rsp side fills the queue, then holds off req; nothing is lost.
module tlv_record_tag_extractor
   import trte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_msg_last,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_out_kind,
   output logic [7:0]  rsp_value_byte,
   output logic [1:0]  rsp_status_code,
   output logic [15:0] rsp_value_count,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type    cfg_ff;
   push_type   push;
   result_type head;
   logic       req_accept;
   logic       q_not_empty;
   logic       q_room_two;

   // Configuration registers: written any cycle, software keeps writes to idle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tag_first_char  <= '0;
         cfg_ff.tag_name_length <= '0;
         cfg_ff.tag_name_xor    <= '0;
         cfg_ff.value_limit     <= VALUE_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_TAG_FIRST_CHAR:  cfg_ff.tag_first_char  <= csr_data[7:0];
            CSR_TAG_NAME_LENGTH: cfg_ff.tag_name_length <= csr_data[7:0];
            CSR_TAG_NAME_XOR:    cfg_ff.tag_name_xor    <= csr_data[7:0];
            CSR_VALUE_LIMIT:     cfg_ff.value_limit     <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_ready  = q_room_two;
   assign req_accept = req_valid && req_ready;

   // Per-byte record parser; results go straight into the queue registers.
   trte_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .msg_byte (req_msg_byte),
      .msg_last (req_msg_last),
      .cfg      (cfg_ff),
      .push     (push)
   );

   trte_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_valid && rsp_ready),
      .head      (head),
      .not_empty (q_not_empty),
      .room_two  (q_room_two)
   );

   assign rsp_valid       = q_not_empty;
   assign rsp_out_kind    = head.out_kind;
   assign rsp_value_byte  = head.value_byte;
   assign rsp_status_code = head.status_code;
   assign rsp_value_count = head.value_count;

endmodule
